@@ rtl/rpa_pkg.sv @@
`timescale 1ns / 1ps
// rpa_pkg: shared types and codes for the register pool allocator
// no dependencies; used by the channel interfaces, the scan unit and the top level

package rpa_pkg;

  localparam int REG_IDX_W = 5;
  localparam int OPCODE_W  = 2;
  localparam int STATUS_W  = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_SAVE    = 2'd2,
    OP_RESTORE = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NOREG = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  // sequencer to scan unit
  typedef struct packed {
    logic start;
    logic down;
    logic step;
  } scan_ctl_t;

  // scan unit to sequencer
  typedef struct packed {
    logic hit;
    logic last;
    logic empty;
  } scan_stat_t;

endpackage

@@ rtl/rpa_if.sv @@
`timescale 1ns / 1ps
// rpa_req_if / rpa_rsp_if: valid/ready channels of the register pool allocator
// depends on rpa_pkg for field widths

interface rpa_req_if;
  import rpa_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [REG_IDX_W-1:0] reg_index;

  modport source (output valid, output opcode, output reg_index, input ready);
  modport sink   (input valid, input opcode, input reg_index, output ready);
endinterface

interface rpa_rsp_if;
  import rpa_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] reg_index_res;
  logic [STATUS_W-1:0]  status;
  logic                 last;

  modport source (output valid, output reg_index_res, output status, output last,
                  input ready);
  modport sink   (input valid, input reg_index_res, input status, input last,
                  output ready);
endinterface

@@ rtl/rpa_scan.sv @@
`timescale 1ns / 1ps
// rpa_scan: bit-serial scan unit, walks a working copy of the map one bit a cycle while ctl.step is high
// depends on rpa_pkg (scan_ctl_t, scan_stat_t)

module rpa_scan #(
  parameter int POOL = 18,
  parameter int IW   = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rpa_pkg::scan_ctl_t   ctl,
  input  logic [POOL-1:0]      load_map,
  output rpa_pkg::scan_stat_t  stat,
  output logic [IW-1:0]        idx
);
  import rpa_pkg::*;

  logic [POOL-1:0] work;
  logic [POOL-1:0] work_next;
  logic [POOL-1:0] rest;
  logic [IW-1:0]   ptr;
  logic            down;

  // bits still to visit once the current one is taken
  always_comb begin
    rest      = work;
    rest[ptr] = 1'b0;
  end

  assign stat.hit   = work[ptr];
  assign stat.last  = ~|rest;
  assign stat.empty = ~|work;
  assign idx        = ptr;

  always_comb begin
    work_next = work;
    if (ctl.start) begin
      work_next = load_map;
    end else if (ctl.step) begin
      work_next = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work <= '0;
    end else begin
      work <= work_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      down <= ctl.down;
      ptr  <= ctl.down ? IW'(POOL - 1) : '0;
    end else if (ctl.step) begin
      ptr <= down ? ptr - 1'b1 : ptr + 1'b1;
    end
  end

endmodule

@@ rtl/register_pool_allocator_top.sv @@
`timescale 1ns / 1ps
// register_pool_allocator_top: used-bit map, sequencer and result register
// depends on rpa_pkg, rpa_if (rpa_req_if, rpa_rsp_if) and rpa_scan

// Usage
//   req carries one item (opcode, reg_index); rsp returns result items
//   (reg_index_res, status, last), last marking the final result of an item.
//   Release is answered straight from the request: the result sits in the
//   output register on the next cycle.
//   Allocate, save and restore go through the scan unit, which tests one bit of
//   a working copy of the map per cycle while rsp does not stall it. Allocate
//   stops at the first free index k; a full pool is seen as soon as the scan starts.
//   Save stops at the highest used index h, restore at the lowest used index l.
//   Each gives one result per used register as the walk meets it.
//   One item is worked on at a time; req.ready is high only while idle and the
//   output register is empty or being drained.
//   A stall on rsp holds the walk at the register to be reported, nothing is lost.
//   Reset (rst, synchronous) frees every register and empties the output.

module register_pool_allocator_top #(
  parameter int NUM_TEMP  = 10,
  parameter int NUM_SAVED = 8
) (
  input logic         clk,
  input logic         rst,
  rpa_req_if.sink     req,
  rpa_rsp_if.source   rsp
);
  import rpa_pkg::*;

  localparam int POOL = NUM_TEMP + NUM_SAVED;
  localparam int IW   = $clog2(POOL);

  // state
  state_t          state;
  state_t          state_next;
  logic [POOL-1:0] used_map;
  logic            op_alloc;

  // handshake helpers
  logic            out_free;
  logic            acc;
  opcode_t         op;
  logic            rel_in_pool;
  logic            rel_result;
  logic [IW-1:0]   rel_idx;

  // scan unit hookup
  scan_ctl_t       ctl;
  scan_stat_t      stat;
  logic [IW-1:0]   scan_idx;
  logic [POOL-1:0] load_map;

  // result staging
  logic                 emit;
  logic [REG_IDX_W-1:0] emit_idx;
  status_t              emit_status;
  logic                 emit_last;
  logic                 set_used;
  logic                 clr_used;

  assign out_free    = !rsp.valid || rsp.ready;
  assign req.ready   = (state == S_IDLE) && out_free;
  assign acc         = req.valid && req.ready;
  assign op          = opcode_t'(req.opcode);
  assign rel_in_pool = 32'(req.reg_index) < POOL;
  assign rel_result  = 32'(req.reg_index) == POOL;
  assign rel_idx     = IW'(req.reg_index);

  // allocate hunts for a clear bit, bursts for set bits
  assign load_map = (op == OP_ALLOC) ? ~used_map : used_map;

  rpa_scan #(
    .POOL (POOL),
    .IW   (IW)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .load_map (load_map),
    .stat     (stat),
    .idx      (scan_idx)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc && op != OP_RELEASE) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (out_free && (stat.empty || (stat.hit && (op_alloc || stat.last)))) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctl         = '0;
    emit        = 1'b0;
    emit_idx    = '0;
    emit_status = ST_OK;
    emit_last   = 1'b1;
    set_used    = 1'b0;
    clr_used    = 1'b0;
    case (state)
      S_IDLE: begin
        if (acc) begin
          if (op == OP_RELEASE) begin
            // result register is silently ignored, anything past it is unknown
            emit        = 1'b1;
            emit_status = (rel_in_pool || rel_result) ? ST_OK : ST_NOREG;
            clr_used    = rel_in_pool;
          end else begin
            ctl.start = 1'b1;
            ctl.down  = (op == OP_RESTORE);
          end
        end
      end
      S_SCAN: begin
        if (stat.empty) begin
          // nothing to find: pool full for allocate, nothing in use for a burst
          if (out_free) begin
            emit        = 1'b1;
            emit_status = op_alloc ? ST_FULL : ST_EMPTY;
          end
        end else if (stat.hit) begin
          if (out_free) begin
            emit      = 1'b1;
            emit_idx  = REG_IDX_W'(scan_idx);
            emit_last = op_alloc | stat.last;
            set_used  = op_alloc;
            ctl.step  = 1'b1;
          end
        end else begin
          ctl.step = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op_alloc <= (op == OP_ALLOC);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_map <= '0;
    end else if (set_used) begin
      used_map[scan_idx] <= 1'b1;
    end else if (clr_used) begin
      used_map[rel_idx] <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (emit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.reg_index_res <= emit_idx;
      rsp.status        <= emit_status;
      rsp.last          <= emit_last;
    end
  end

  // checks
  a_alloc_marks: assert property (@(posedge clk) disable iff (rst)
    set_used |=> used_map[$past(scan_idx)])
    else $error("allocated register not marked used");

  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_FULL |-> &used_map)
    else $error("pool reported full with a free register");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_EMPTY |-> rsp.last && ~|used_map)
    else $error("empty burst result malformed");

  a_burst_keeps_map: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN && !op_alloc |=> $stable(used_map))
    else $error("map changed during save or restore burst");

endmodule
